@@ sv/tsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared codes and widths for the touch swipe direction detector.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int TYPE_W   = 5;
	localparam int CODE_W   = 10;
	localparam int VALUE_W  = 16;
	localparam int DIR_W    = 3;
	localparam int MARGIN_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
	localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;

	localparam logic [CODE_W-1:0] AXIS_X       = 10'd0;
	localparam logic [CODE_W-1:0] AXIS_Y       = 10'd1;
	localparam logic [CODE_W-1:0] TOUCH_BUTTON = 10'd330;

	localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MARGIN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_MARGIN = 1'd1;

	localparam logic [MARGIN_W-1:0] VERTICAL_MARGIN_RST   = 16'd100;
	localparam logic [MARGIN_W-1:0] HORIZONTAL_MARGIN_RST = 16'd50;

endpackage

@@ sv/tsd_track.sv @@
// ----------------------------------------------------------------------------
// tsd_track
// Decodes touch events, tracks start and latest coordinates and captures
// a snapshot of them on every touch release.
// ----------------------------------------------------------------------------
module tsd_track #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tsd_pkg::TYPE_W-1:0]    event_type,
	input  logic [tsd_pkg::CODE_W-1:0]    event_code,
	input  logic [tsd_pkg::VALUE_W-1:0]   event_value,
	input  logic                          snap_ready,
	output logic                          snap_valid,
	output logic [COORD_BITS-1:0]         start_x,
	output logic [COORD_BITS-1:0]         start_y,
	output logic [COORD_BITS-1:0]         latest_x,
	output logic [COORD_BITS-1:0]         latest_y
);
	import tsd_pkg::*;

	logic [COORD_BITS-1:0] start_x_q, start_y_q, latest_x_q, latest_y_q;
	logic                  await_x_q, await_y_q;
	logic                  valid_s1;
	logic [COORD_BITS-1:0] start_x_s1, start_y_s1, latest_x_s1, latest_y_s1;
	logic [COORD_BITS-1:0] coord;
	logic                  accept, is_x, is_y, is_release;

	// saturate the coordinate into the tracked range
	generate
		if (COORD_BITS >= VALUE_W) begin : g_wide
			assign coord = COORD_BITS'(event_value);
		end else begin : g_narrow
			localparam logic [VALUE_W-1:0] LIMIT = VALUE_W'((1 << COORD_BITS) - 1);
			assign coord = (event_value > LIMIT) ? {COORD_BITS{1'b1}}
				: event_value[COORD_BITS-1:0];
		end
	endgenerate

	assign in_stall   = valid_s1 && !snap_ready;
	assign accept     = in_valid && !in_stall;
	assign is_x       = (event_type == EVT_ABS) && (event_code == AXIS_X);
	assign is_y       = (event_type == EVT_ABS) && (event_code == AXIS_Y);
	assign is_release = (event_type == EVT_KEY) && (event_code == TOUCH_BUTTON)
		&& (event_value == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			latest_x_q <= '0;
			latest_y_q <= '0;
			await_x_q  <= 1'b1;
			await_y_q  <= 1'b1;
		end else if (accept) begin
			if (is_x) begin
				latest_x_q <= coord;
				await_x_q  <= 1'b0;
				if (await_x_q)
					start_x_q <= coord;
			end
			if (is_y) begin
				latest_y_q <= coord;
				await_y_q  <= 1'b0;
				if (await_y_q)
					start_y_q <= coord;
			end
			if (is_release) begin
				await_x_q <= 1'b1;
				await_y_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || snap_ready) begin
			valid_s1 <= accept && is_release;
		end
	end

	// snapshot of the swipe at release
	always_ff @(posedge clk) begin
		if (accept && is_release) begin
			start_x_s1  <= start_x_q;
			start_y_s1  <= start_y_q;
			latest_x_s1 <= latest_x_q;
			latest_y_s1 <= latest_y_q;
		end
	end

	assign snap_valid = valid_s1;
	assign start_x    = start_x_s1;
	assign start_y    = start_y_s1;
	assign latest_x   = latest_x_s1;
	assign latest_y   = latest_y_s1;

endmodule

@@ sv/tsd_classify.sv @@
// ----------------------------------------------------------------------------
// tsd_classify
// Compares vertical and horizontal travel against the margins and holds
// the resulting direction in the output register.
// ----------------------------------------------------------------------------
module tsd_classify #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          snap_valid,
	output logic                          snap_ready,
	input  logic [COORD_BITS-1:0]         start_x,
	input  logic [COORD_BITS-1:0]         start_y,
	input  logic [COORD_BITS-1:0]         latest_x,
	input  logic [COORD_BITS-1:0]         latest_y,
	input  logic [tsd_pkg::MARGIN_W-1:0]  vertical_margin,
	input  logic [tsd_pkg::MARGIN_W-1:0]  horizontal_margin,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tsd_pkg::DIR_W-1:0]     swipe_direction
);
	import tsd_pkg::*;

	localparam int BASE_W = (COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W;
	localparam int SUM_W  = BASE_W + 1;

	logic [COORD_BITS-1:0] dx, dy;
	logic                  x_neg, y_neg;
	logic [SUM_W-1:0]      dx_w, dy_w, v_lim, h_lim;
	logic [DIR_W-1:0]      dir;
	logic                  valid_q;
	logic [DIR_W-1:0]      dir_q;

	assign x_neg = latest_x < start_x;
	assign y_neg = latest_y < start_y;
	assign dx    = x_neg ? (start_x - latest_x) : (latest_x - start_x);
	assign dy    = y_neg ? (start_y - latest_y) : (latest_y - start_y);
	assign dx_w  = SUM_W'(dx);
	assign dy_w  = SUM_W'(dy);
	assign v_lim = SUM_W'(vertical_margin) + dx_w;
	assign h_lim = SUM_W'(horizontal_margin) + dy_w;

	always_comb begin
		if (dy_w > v_lim)
			dir = y_neg ? DIR_UP : DIR_DOWN;
		else if (dx_w > h_lim)
			dir = x_neg ? DIR_LEFT : DIR_RIGHT;
		else
			dir = DIR_NONE;
	end

	assign snap_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (snap_ready) begin
			valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid)
			dir_q <= dir;
	end

	assign out_valid       = valid_q;
	assign swipe_direction = dir_q;

endmodule

@@ sv/touch_swipe_direction_detector.sv @@
// ----------------------------------------------------------------------------
// touch_swipe_direction_detector
// Classifies a touch swipe as up, down, left, right or none on each
// touch release, from the first and latest X/Y positions of the touch.
//
//   channel  signals                                        dir
//   in       in_valid, in_stall, event_type/code/value      sink
//   out      out_valid, out_stall, swipe_direction          source
//   cfg      cfg_wr_en, cfg_index, cfg_wdata                sink
//
// one event per cycle while in_stall is low; a release gives its direction
// through the snapshot stage and the output register, other events give no result
// coordinate state updates on the accepting edge
// arst_n clears control state and loads the default margins
// out_stall backs up through one snapshot stage before in_stall rises
// ----------------------------------------------------------------------------
module touch_swipe_direction_detector #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tsd_pkg::TYPE_W-1:0]     event_type,
	input  logic [tsd_pkg::CODE_W-1:0]     event_code,
	input  logic [tsd_pkg::VALUE_W-1:0]    event_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tsd_pkg::DIR_W-1:0]      swipe_direction,
	input  logic                           cfg_wr_en,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsd_pkg::MARGIN_W-1:0]   cfg_wdata
);
	import tsd_pkg::*;

	logic [MARGIN_W-1:0]   vmargin_q, hmargin_q;
	logic                  snap_valid, snap_ready;
	logic [COORD_BITS-1:0] start_x, start_y, latest_x, latest_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmargin_q <= VERTICAL_MARGIN_RST;
			hmargin_q <= HORIZONTAL_MARGIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_VERTICAL_MARGIN:   vmargin_q <= cfg_wdata;
				REG_HORIZONTAL_MARGIN: hmargin_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	tsd_track #(.COORD_BITS(COORD_BITS)) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.event_type  (event_type),
		.event_code  (event_code),
		.event_value (event_value),
		.snap_ready  (snap_ready),
		.snap_valid  (snap_valid),
		.start_x     (start_x),
		.start_y     (start_y),
		.latest_x    (latest_x),
		.latest_y    (latest_y)
	);

	tsd_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.clk               (clk),
		.arst_n            (arst_n),
		.snap_valid        (snap_valid),
		.snap_ready        (snap_ready),
		.start_x           (start_x),
		.start_y           (start_y),
		.latest_x          (latest_x),
		.latest_y          (latest_y),
		.vertical_margin   (vmargin_q),
		.horizontal_margin (hmargin_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.swipe_direction   (swipe_direction)
	);

endmodule

@@ sv/tsd_checker.sv @@
// ----------------------------------------------------------------------------
// tsd_checker
// Port-level checks for the touch swipe direction detector.
// ----------------------------------------------------------------------------
module tsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [tsd_pkg::DIR_W-1:0]  swipe_direction
);
	import tsd_pkg::*;

	// held result stays put while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(swipe_direction))
		else $error("output transaction changed while stalled");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> swipe_direction <= DIR_RIGHT)
		else $error("direction code out of range");

	// input backs up only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("output valid during reset");

	// a transaction with the output free cannot be refused
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> !in_stall)
		else $error("input stalled while the output is empty");

endmodule

bind touch_swipe_direction_detector tsd_checker u_tsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.swipe_direction (swipe_direction)
);

@@ bench/touch_swipe_direction_detector_test.sv @@
// ----------------------------------------------------------------------------
// touch_swipe_direction_detector_test
// Self-checking bench for the swipe direction detector. Event transactions
// go through a tracking copy of the swipe state that predicts the direction
// of every release; the result channel is compared against that queue.
// Covers directed corner swipes, margin extremes, and random swipe sequences
// with noise, under phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module touch_swipe_direction_detector_test;
	import tsd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [TYPE_W-1:0] event_type;
	logic [CODE_W-1:0] event_code;
	logic [VALUE_W-1:0] event_value;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DIR_W-1:0] swipe_direction;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MARGIN_W-1:0] cfg_wdata;

	// tracked swipe state
	logic [MARGIN_W-1:0] vert_margin;
	logic [MARGIN_W-1:0] horiz_margin;
	logic [15:0] first_x, first_y, last_x, last_y;
	logic arm_x, arm_y;

	logic [DIR_W-1:0] expected_dirs[$];
	logic [DIR_W-1:0] want_dir;
	int errors = 0;
	int events_sent = 0;
	int swipe_events = 0;
	int releases_seen = 0;
	int dir_count[5];
	int idle_pct = 0;
	int stall_pct = 0;

	touch_swipe_direction_detector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.event_type(event_type),
		.event_code(event_code),
		.event_value(event_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.swipe_direction(swipe_direction),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [DIR_W-1:0] swipe_class();
		logic [17:0] dx, dy;
		dx = (last_x > first_x) ? 18'(last_x - first_x) : 18'(first_x - last_x);
		dy = (last_y > first_y) ? 18'(last_y - first_y) : 18'(first_y - last_y);
		if (dy > 18'(vert_margin) + dx)
			return (last_y < first_y) ? DIR_UP : DIR_DOWN;
		if (dx > 18'(horiz_margin) + dy)
			return (last_x < first_x) ? DIR_LEFT : DIR_RIGHT;
		return DIR_NONE;
	endfunction

	// update tracked state for one accepted transaction
	task automatic track_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
			input logic [VALUE_W-1:0] v);
		logic [DIR_W-1:0] d;
		if (t == EVT_ABS && c == AXIS_X) begin
			if (arm_x) begin
				arm_x = 1'b0;
				first_x = v;
			end
			last_x = v;
			swipe_events++;
		end else if (t == EVT_ABS && c == AXIS_Y) begin
			if (arm_y) begin
				arm_y = 1'b0;
				first_y = v;
			end
			last_y = v;
			swipe_events++;
		end else if (t == EVT_KEY && c == TOUCH_BUTTON && v == '0) begin
			arm_x = 1'b1;
			arm_y = 1'b1;
			d = swipe_class();
			expected_dirs.push_back(d);
			dir_count[d]++;
			swipe_events++;
		end
	endtask

	task automatic send_event(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
			input logic [VALUE_W-1:0] v);
		logic stalled;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		event_type <= t;
		event_code <= c;
		event_value <= v;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled)
				break;
		end
		events_sent++;
		track_event(t, c, v);
	endtask

	task automatic send_release();
		send_event(EVT_KEY, TOUCH_BUTTON, '0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_dirs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MARGIN_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_VERTICAL_MARGIN)
			vert_margin = val;
		else if (idx == REG_HORIZONTAL_MARGIN)
			horiz_margin = val;
	endtask

	task automatic set_margins(input logic [MARGIN_W-1:0] vm, input logic [MARGIN_W-1:0] hm);
		wait_idle();
		write_reg(REG_VERTICAL_MARGIN, vm);
		write_reg(REG_HORIZONTAL_MARGIN, hm);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] near(input logic [15:0] c, input int spread);
		int v;
		v = int'(c) + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic send_noise();
		case ($urandom_range(3))
			0: send_event(EVT_KEY, TOUCH_BUTTON, 16'($urandom_range(1, 65535)));
			1: send_event(EVT_ABS, 10'($urandom_range(2, 1023)), 16'($urandom));
			default: send_event(5'($urandom), 10'($urandom), 16'($urandom));
		endcase
	endtask

	// one swipe: start position, a few moves, release; sometimes broken
	task automatic run_swipe();
		logic [15:0] sx, sy;
		int spread;
		int moves;
		spread = ($urandom_range(9) == 0) ? 65535 : $urandom_range(20, 600);
		sx = 16'($urandom);
		sy = 16'($urandom);
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1))
				send_noise();
			send_release();
			return;
		end
		if ($urandom_range(1)) begin
			send_event(EVT_ABS, AXIS_X, sx);
			send_event(EVT_ABS, AXIS_Y, sy);
		end else begin
			send_event(EVT_ABS, AXIS_Y, sy);
			send_event(EVT_ABS, AXIS_X, sx);
		end
		moves = $urandom_range(1, 5);
		repeat (moves) begin
			case ($urandom_range(2))
				0: send_event(EVT_ABS, AXIS_X, near(sx, spread));
				1: send_event(EVT_ABS, AXIS_Y, near(sy, spread));
				default: begin
					send_event(EVT_ABS, AXIS_X, near(sx, spread));
					send_event(EVT_ABS, AXIS_Y, near(sy, spread));
				end
			endcase
			if ($urandom_range(7) == 0)
				send_noise();
		end
		send_release();
	endtask

	task automatic test_directed();
		// release straight after reset, nothing touched yet
		send_release();
		send_event(EVT_KEY, TOUCH_BUTTON, 16'd1);
		send_event(EVT_KEY, TOUCH_BUTTON, 16'hffff);
		// down
		send_event(EVT_ABS, AXIS_X, 16'd1000);
		send_event(EVT_ABS, AXIS_Y, 16'd1000);
		send_event(EVT_ABS, AXIS_Y, 16'd1500);
		send_release();
		// up from the bottom corner
		send_event(EVT_ABS, AXIS_X, 16'hffff);
		send_event(EVT_ABS, AXIS_Y, 16'hffff);
		send_event(EVT_ABS, AXIS_Y, 16'd0);
		send_release();
		// right
		send_event(EVT_ABS, AXIS_Y, 16'd0);
		send_event(EVT_ABS, AXIS_X, 16'd0);
		send_event(EVT_ABS, AXIS_X, 16'd200);
		send_release();
		// left across the full range
		send_event(EVT_ABS, AXIS_X, 16'hffff);
		send_event(EVT_ABS, AXIS_Y, 16'd300);
		send_event(EVT_ABS, AXIS_X, 16'd0);
		send_release();
		// release with no new positions reuses the previous swipe
		send_release();
		// vertical travel exactly at the margin plus horizontal travel is not enough
		send_event(EVT_ABS, AXIS_X, 16'd500);
		send_event(EVT_ABS, AXIS_Y, 16'd500);
		send_event(EVT_ABS, AXIS_X, 16'd600);
		send_event(EVT_ABS, AXIS_Y, 16'd700);
		send_release();
		// ignored events
		send_event(5'd31, 10'd1023, 16'hffff);
		send_event(EVT_ABS, TOUCH_BUTTON, 16'd0);
		send_event(EVT_KEY, AXIS_X, 16'd0);
		send_event(EVT_ABS, 10'd2, 16'd7);
		send_release();
	endtask

	task automatic test_margin_extremes();
		logic [MARGIN_W-1:0] vms[4] = '{16'd0, 16'hffff, 16'd0, 16'hffff};
		logic [MARGIN_W-1:0] hms[4] = '{16'd0, 16'hffff, 16'hffff, 16'd0};
		for (int i = 0; i < 4; i++) begin
			set_margins(vms[i], hms[i]);
			// diagonal ties and single-step differences
			send_event(EVT_ABS, AXIS_X, 16'd100);
			send_event(EVT_ABS, AXIS_Y, 16'd100);
			send_event(EVT_ABS, AXIS_X, 16'd110);
			send_event(EVT_ABS, AXIS_Y, 16'd90);
			send_release();
			send_event(EVT_ABS, AXIS_X, 16'd100);
			send_event(EVT_ABS, AXIS_Y, 16'd100);
			send_event(EVT_ABS, AXIS_Y, 16'd111);
			send_event(EVT_ABS, AXIS_X, 16'd110);
			send_release();
			repeat (6) run_swipe();
		end
		set_margins(VERTICAL_MARGIN_RST, HORIZONTAL_MARGIN_RST);
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int target);
		int start_count;
		set_margins(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
		idle_pct = idle;
		stall_pct = stall;
		start_count = swipe_events;
		while (swipe_events - start_count < target) begin
			run_swipe();
			// hold off until the block has drained
			if ($urandom_range(19) == 0)
				wait_idle();
		end
		wait_idle();
		idle_pct = 0;
		stall_pct = 0;
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			releases_seen++;
			if (expected_dirs.size() == 0) begin
				$display("%0t: unexpected swipe_direction %0d", $time, swipe_direction);
				errors++;
			end else begin
				want_dir = expected_dirs.pop_front();
				if (swipe_direction !== want_dir) begin
					$display("%0t: swipe_direction expected %0d actual %0d",
						$time, want_dir, swipe_direction);
					errors++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("FAIL touch_swipe_direction_detector");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		event_type <= '0;
		event_code <= '0;
		event_value <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		vert_margin = VERTICAL_MARGIN_RST;
		horiz_margin = HORIZONTAL_MARGIN_RST;
		first_x = '0;
		first_y = '0;
		last_x = '0;
		last_y = '0;
		arm_x = 1'b1;
		arm_y = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_margin_extremes();
		test_random_phase(0, 0, 350);
		test_random_phase(47, 0, 350);
		test_random_phase(0, 47, 350);
		test_random_phase(20, 20, 350);
		wait_idle();

		$display("sent %0d transactions, %0d swipe events, %0d directions checked",
			events_sent, swipe_events, releases_seen);
		$display("none %0d up %0d down %0d left %0d right %0d",
			dir_count[0], dir_count[1], dir_count[2], dir_count[3], dir_count[4]);
		if (errors == 0)
			$display("PASS touch_swipe_direction_detector");
		else
			$display("FAIL touch_swipe_direction_detector");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tsd_pkg.sv
sv/tsd_track.sv
sv/tsd_classify.sv
sv/touch_swipe_direction_detector.sv
sv/tsd_checker.sv
bench/touch_swipe_direction_detector_test.sv
